// ===== rtl/tkal_pkg.sv =====
// ----------------------------------------------------------------------------
// tkal_pkg
// Shared widths, codes and defaults of the kth-ancestor lifting core.
// ----------------------------------------------------------------------------
package tkal_pkg;

  localparam int NODE_W  = 12;
  localparam int CMD_W   = 2;
  localparam int STEPS_W = 32;
  localparam int CNT_W   = 13;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam int MAX_NODES_DEF = 4096;
  localparam int LEVELS_DEF    = 12;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 13'd4096;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_PARENT = 2'd0,
    CMD_BUILD      = 2'd1,
    CMD_QUERY      = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_NODE_COUNT = 1'b0,
    REG_NONE       = 1'b1
  } reg_idx_t;

endpackage

// ===== rtl/tkal_cfg.sv =====
// ----------------------------------------------------------------------------
// tkal_cfg
// APB register block holding the node count used by the table build.
// ----------------------------------------------------------------------------
module tkal_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkal_pkg::PADDR_W-1:0]  paddr,
  input  logic [tkal_pkg::PDATA_W-1:0]  pwdata,
  output logic [tkal_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output logic [tkal_pkg::CNT_W-1:0]    node_count
);

  logic [tkal_pkg::CNT_W-1:0] node_count_r;
  logic [tkal_pkg::CNT_W-1:0] node_count_nxt;
  tkal_pkg::reg_idx_t         reg_idx;

  assign reg_idx = tkal_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    node_count_nxt = node_count_r;
    if (psel && penable && pwrite && (reg_idx == tkal_pkg::REG_NODE_COUNT)) begin
      node_count_nxt = pwdata[tkal_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= tkal_pkg::NODE_COUNT_RST;
    end else begin
      node_count_r <= node_count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == tkal_pkg::REG_NODE_COUNT) begin
      prdata = {{(tkal_pkg::PDATA_W-tkal_pkg::CNT_W){1'b0}}, node_count_r};
    end
  end

  assign node_count = node_count_r;

endmodule

// ===== rtl/tkal_engine.sv =====
// ----------------------------------------------------------------------------
// tkal_engine
// Jump table memory and the sequencer that clears, loads, builds and climbs it
// through a single read port, one dependent lookup at a time.
// ----------------------------------------------------------------------------
module tkal_engine #(
  parameter int MAX_NODES = tkal_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tkal_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tkal_pkg::CNT_W-1:0]    node_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tkal_pkg::CMD_W-1:0]    in_command,
  input  logic [tkal_pkg::NODE_W-1:0]   in_node,
  input  logic [tkal_pkg::NODE_W-1:0]   in_parent_node,
  input  logic [tkal_pkg::STEPS_W-1:0]  in_steps,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tkal_pkg::NODE_W-1:0]   out_ancestor_node
);

  localparam int DEPTH    = LEVELS * MAX_NODES;
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CLR_LAST = DEPTH - 1;
  localparam int NW       = tkal_pkg::NODE_W;
  localparam int CW       = tkal_pkg::CNT_W;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_BLD_RD   = 8'b0000_0100,
    ST_BLD_MID  = 8'b0000_1000,
    ST_BLD_WR   = 8'b0001_0000,
    ST_QRY_SCAN = 8'b0010_0000,
    ST_QRY_LOAD = 8'b0100_0000,
    ST_DONE     = 8'b1000_0000
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] lvl,
                                            input logic [CW-1:0] idx);
    return AW'(lvl) * AW'(MAX_NODES) + AW'(idx);
  endfunction

  function automatic logic [NW-1:0] clamp_node(input logic [NW-1:0] n);
    return (32'(n) < 32'(MAX_NODES)) ? n : '0;
  endfunction

  state_t            state_r,     state_nxt;
  logic [AW-1:0]     clr_addr_r,  clr_addr_nxt;
  logic [LW-1:0]     lvl_r,       lvl_nxt;
  logic [CW-1:0]     v_r,         v_nxt;
  logic [CW-1:0]     count_r,     count_nxt;
  logic [NW-1:0]     cur_r,       cur_nxt;
  logic [LEVELS-1:0] steps_r,     steps_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NW-1:0]     out_node_r,  out_node_nxt;

  logic [NW-1:0]     mem [DEPTH];
  logic [NW-1:0]     rd_data_r;
  logic              we;
  logic [AW-1:0]     wa;
  logic [NW-1:0]     wd;
  logic [AW-1:0]     ra;

  logic              out_load;
  logic [CW-1:0]     build_count;
  logic              lvl_last;
  logic              node_ok;
  logic              parent_ok;
  logic              steps_high;
  tkal_pkg::cmd_t    cmd;

  assign cmd         = tkal_pkg::cmd_t'(in_command);
  assign build_count = (32'(node_count) > 32'(MAX_NODES)) ? CW'(MAX_NODES) : node_count;
  assign lvl_last    = (lvl_r == LW'(LEVELS - 1));
  assign node_ok     = (32'(in_node) < 32'(MAX_NODES));
  assign parent_ok   = (32'(in_parent_node) < 32'(MAX_NODES));
  assign steps_high  = ((in_steps >> LEVELS) != '0);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    lvl_nxt      = lvl_r;
    v_nxt        = v_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    steps_nxt    = steps_r;
    out_load     = 1'b0;
    we           = 1'b0;
    wa           = '0;
    wd           = '0;
    ra           = '0;
    unique case (state_r)
      ST_CLEAR: begin
        we           = 1'b1;
        wa           = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(CLR_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd)
            tkal_pkg::CMD_SET_PARENT: begin
              if ((in_node != '0) && node_ok && parent_ok) begin
                we = 1'b1;
                wa = addr_of('0, CW'(in_node));
                wd = in_parent_node;
              end
            end
            tkal_pkg::CMD_BUILD: begin
              count_nxt = build_count;
              lvl_nxt   = LW'(1);
              v_nxt     = '0;
              if ((build_count != '0) && (LEVELS > 1)) begin
                state_nxt = ST_BLD_RD;
              end
            end
            tkal_pkg::CMD_QUERY: begin
              lvl_nxt   = '0;
              steps_nxt = in_steps[LEVELS-1:0];
              if (!node_ok || steps_high) begin
                cur_nxt   = '0;
                state_nxt = ST_DONE;
              end else begin
                cur_nxt   = in_node;
                state_nxt = ST_QRY_SCAN;
              end
            end
            tkal_pkg::CMD_NOP: begin
            end
          endcase
        end
      end
      ST_BLD_RD: begin
        ra        = addr_of(lvl_r - LW'(1), v_r);
        state_nxt = ST_BLD_MID;
      end
      ST_BLD_MID: begin
        ra        = addr_of(lvl_r - LW'(1), CW'(clamp_node(rd_data_r)));
        state_nxt = ST_BLD_WR;
      end
      ST_BLD_WR: begin
        we        = 1'b1;
        wa        = addr_of(lvl_r, v_r);
        wd        = rd_data_r;
        state_nxt = ST_BLD_RD;
        if (v_r == count_r - CW'(1)) begin
          v_nxt = '0;
          if (lvl_last) begin
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r + LW'(1);
          end
        end else begin
          v_nxt = v_r + CW'(1);
        end
      end
      ST_QRY_SCAN: begin
        if (steps_r[0]) begin
          ra        = addr_of(lvl_r, CW'(cur_r));
          state_nxt = ST_QRY_LOAD;
        end else begin
          steps_nxt = steps_r >> 1;
          if (lvl_last) begin
            state_nxt = ST_DONE;
          end else begin
            lvl_nxt = lvl_r + LW'(1);
          end
        end
      end
      ST_QRY_LOAD: begin
        cur_nxt   = clamp_node(rd_data_r);
        steps_nxt = steps_r >> 1;
        if (lvl_last) begin
          state_nxt = ST_DONE;
        end else begin
          lvl_nxt   = lvl_r + LW'(1);
          state_nxt = ST_QRY_SCAN;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_node_nxt  = out_node_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_node_nxt  = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lvl_r      <= lvl_nxt;
    v_r        <= v_nxt;
    count_r    <= count_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    out_node_r <= out_node_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data_r <= mem[ra];
  end

  assign in_ready          = (state_r == ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ancestor_node = out_node_r;

endmodule

// ===== rtl/tree_kth_ancestor_lifting_core.sv =====
// ----------------------------------------------------------------------------
// tree_kth_ancestor_lifting_core
// Binary lifting kth-ancestor unit over a rooted tree held in a jump table.
// ----------------------------------------------------------------------------
// A parent load is written in the cycle it is accepted. A query is accepted,
// then climbs the LEVELS levels: a clear step bit passes the scan state, a
// set bit the scan and load states; the done state then hands its word to the
// output register once that is free. A node out of range, or a step count with
// a bit at or above bit LEVELS, goes straight to done. A build is accepted,
// then takes min(node_count, MAX_NODES) entries of each level 1 to LEVELS-1
// through the read, middle and write states, all set by the one read port of
// the jump table RAM, whose registered read feeds the next lookup. After reset
// a clearing pass zeroes all LEVELS*MAX_NODES entries; no word is accepted
// until then, while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module tree_kth_ancestor_lifting_core #(
  parameter int MAX_NODES = tkal_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = tkal_pkg::LEVELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tkal_pkg::PADDR_W-1:0]  paddr,
  input  logic [tkal_pkg::PDATA_W-1:0]  pwdata,
  output logic [tkal_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tkal_pkg::CMD_W-1:0]    in_command,
  input  logic [tkal_pkg::NODE_W-1:0]   in_node,
  input  logic [tkal_pkg::NODE_W-1:0]   in_parent_node,
  input  logic [tkal_pkg::STEPS_W-1:0]  in_steps,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tkal_pkg::NODE_W-1:0]   out_ancestor_node
);

  logic [tkal_pkg::CNT_W-1:0] node_count;

  tkal_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .node_count (node_count)
  );

  tkal_engine #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .node_count        (node_count),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_node           (in_node),
    .in_parent_node    (in_parent_node),
    .in_steps          (in_steps),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ancestor_node (out_ancestor_node)
  );

endmodule

// ===== rtl/tkal_checker.sv =====
// ----------------------------------------------------------------------------
// tkal_checker
// Port-level checks of the kth-ancestor lifting core, bound to the top level.
// ----------------------------------------------------------------------------
module tkal_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [tkal_pkg::CMD_W-1:0]   in_command,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tkal_pkg::NODE_W-1:0]  out_ancestor_node
);

  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ancestor_node))
    else $error("stalled output word changed or dropped");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid
      && (in_command == tkal_pkg::CMD_SET_PARENT) |=> !out_valid)
    else $error("parent load produced an output word");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == tkal_pkg::CMD_QUERY) |=> !in_ready)
    else $error("input ready while a query climbs");

endmodule

bind tree_kth_ancestor_lifting_core tkal_checker u_tkal_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_ancestor_node (out_ancestor_node)
);
